// ----- rtl/core/tkns_pkg.sv -----
// ----------------------------------------------------------------------------
// tkns_pkg
// Shared types, constants and note tables of the touch keyboard note selector.
// ----------------------------------------------------------------------------
package tkns_pkg;

	// Geometry
	localparam int KEYS    = 8;
	localparam int NOTES   = 13;
	localparam int LEVEL_W = 16;
	localparam int NOTE_W  = 4;
	localparam int IDLE_W  = 16;
	localparam int CFG_W   = 16;
	localparam int CFG_IW  = 2;
	localparam int PAIRS   = 5;

	// Baseline memory: one row holds the baselines of all keys
	localparam int BASE_W     = KEYS * LEVEL_W;
	localparam int BASE_DEPTH = 1;

	// Register reset values
	localparam logic [CFG_W-1:0] SINGLE_DELTA_RST = 16'd1700;
	localparam logic [CFG_W-1:0] PAIR_DELTA_RST   = 16'd1200;
	localparam logic [CFG_W-1:0] IDLE_LIMIT_RST   = 16'd1200;

	// Lower key of each sharp pair; the upper key is the next one
	localparam int PAIR_LO [PAIRS] = '{0, 1, 3, 4, 5};

	// Request kinds
	localparam logic KIND_CAL  = 1'b0;
	localparam logic KIND_SCAN = 1'b1;

	// Register indexes
	typedef enum logic [CFG_IW-1:0] {
		CFG_SINGLE = 2'd0,
		CFG_PAIR   = 2'd1,
		CFG_IDLE   = 2'd2
	} cfg_idx_t;

	// Result events
	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_STOP  = 2'd1,
		EV_START = 2'd2
	} event_t;

	typedef struct packed {
		logic              hit;
		logic [NOTE_W-1:0] idx;
	} note_hit_t;

	// Map a key mask to its note
	function automatic note_hit_t note_lookup(input logic [KEYS-1:0] mask);
		note_hit_t r;
		r.hit = 1'b1;
		case (mask)
			8'h01:   r.idx = 4'd0;
			8'h03:   r.idx = 4'd1;
			8'h02:   r.idx = 4'd2;
			8'h06:   r.idx = 4'd3;
			8'h04:   r.idx = 4'd4;
			8'h08:   r.idx = 4'd5;
			8'h18:   r.idx = 4'd6;
			8'h10:   r.idx = 4'd7;
			8'h30:   r.idx = 4'd8;
			8'h20:   r.idx = 4'd9;
			8'h60:   r.idx = 4'd10;
			8'h40:   r.idx = 4'd11;
			8'h80:   r.idx = 4'd12;
			default: begin
				r.hit = 1'b0;
				r.idx = '0;
			end
		endcase
		return r;
	endfunction

	// Sample timer reload value of a note
	function automatic logic [LEVEL_W-1:0] note_period(input logic [NOTE_W-1:0] idx);
		logic [LEVEL_W-1:0] p;
		case (idx)
			4'd0:    p = 16'd8533;
			4'd1:    p = 16'd8067;
			4'd2:    p = 16'd7559;
			4'd3:    p = 16'd7111;
			4'd4:    p = 16'd6761;
			4'd5:    p = 16'd6358;
			4'd6:    p = 16'd6000;
			4'd7:    p = 16'd5647;
			4'd8:    p = 16'd5333;
			4'd9:    p = 16'd5026;
			4'd10:   p = 16'd4776;
			4'd11:   p = 16'd4528;
			4'd12:   p = 16'd4248;
			default: p = '0;
		endcase
		return p;
	endfunction

	// Level exceeds baseline by more than delta
	function automatic logic rises_over(input logic [LEVEL_W-1:0] level,
	                                    input logic [LEVEL_W-1:0] base,
	                                    input logic [LEVEL_W-1:0] delta);
		logic [LEVEL_W:0] diff;
		diff = {1'b0, level} - {1'b0, base};
		return (level > base) && (diff[LEVEL_W-1:0] > delta);
	endfunction

endpackage

// ----- rtl/core/touch_keyboard_note_selector.sv -----
// ----------------------------------------------------------------------------
// touch_keyboard_note_selector
// Turns eight touch levels per request into a key mask, a note and its
// start/stop events, with per-key baselines captured by calibrate requests.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the input is not stalled and
// returns exactly one result per request: the baseline row is read from the
// baseline memory while the levels are registered into stage 1, then the key
// mask, the note and the next player state are formed into the output register.
// A calibrate request writes the whole baseline row at acceptance, so the very
// next request already sees it; until the first calibrate the baselines read
// as zero. The output register lets a new request enter while a result still
// waits, and the input stalls only when the output is stalled and full.
module touch_keyboard_note_selector (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration
	input  logic                                cfg_we,
	input  logic [tkns_pkg::CFG_IW-1:0]         cfg_index,
	input  logic [tkns_pkg::CFG_W-1:0]          cfg_data,
	// Request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic [tkns_pkg::LEVEL_W-1:0]        level_0,
	input  logic [tkns_pkg::LEVEL_W-1:0]        level_1,
	input  logic [tkns_pkg::LEVEL_W-1:0]        level_2,
	input  logic [tkns_pkg::LEVEL_W-1:0]        level_3,
	input  logic [tkns_pkg::LEVEL_W-1:0]        level_4,
	input  logic [tkns_pkg::LEVEL_W-1:0]        level_5,
	input  logic [tkns_pkg::LEVEL_W-1:0]        level_6,
	input  logic [tkns_pkg::LEVEL_W-1:0]        level_7,
	// Result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          event_res,
	output logic [tkns_pkg::NOTE_W-1:0]         note_index,
	output logic [tkns_pkg::LEVEL_W-1:0]        note_period,
	output logic [tkns_pkg::KEYS-1:0]           key_mask,
	output logic                                playing,
	output logic                                power_off
);

	localparam int KEYS    = tkns_pkg::KEYS;
	localparam int LEVEL_W = tkns_pkg::LEVEL_W;
	localparam int IDLE_W  = tkns_pkg::IDLE_W;

	// Configuration registers
	logic [tkns_pkg::CFG_W-1:0] single_delta_q;
	logic [tkns_pkg::CFG_W-1:0] pair_delta_q;
	logic [tkns_pkg::CFG_W-1:0] idle_limit_q;

	// Player state
	logic [KEYS-1:0]   held_mask_q;
	logic              sounding_q;
	logic [IDLE_W-1:0] idle_q;
	logic              shutdown_q;
	logic              base_valid_q;

	// Stage 1
	logic                s1_valid_q;
	logic                kind_s1;
	logic                bvalid_s1;
	logic [LEVEL_W-1:0]  level_s1 [KEYS];

	// Output register
	logic                       out_valid_q;
	tkns_pkg::event_t           event_q;
	logic [tkns_pkg::NOTE_W-1:0] note_q;
	logic [LEVEL_W-1:0]         period_q;
	logic [KEYS-1:0]            mask_q;
	logic                       playing_q;
	logic                       power_q;

	logic                       in_acc;
	logic                       s1_adv;
	logic [LEVEL_W-1:0]         lv_in [KEYS];
	logic [tkns_pkg::BASE_W-1:0] base_wdata;
	logic [tkns_pkg::BASE_W-1:0] base_rdata;

	// Next-state values
	logic [KEYS-1:0]             above_single;
	logic [KEYS-1:0]             above_pair;
	logic [KEYS-1:0]             scan_mask;
	tkns_pkg::note_hit_t         hit;
	tkns_pkg::event_t            ev_n;
	logic [tkns_pkg::NOTE_W-1:0] note_n;
	logic [LEVEL_W-1:0]          period_n;
	logic [KEYS-1:0]             mask_n;
	logic [KEYS-1:0]             held_n;
	logic                        sounding_n;
	logic [IDLE_W-1:0]           idle_n;
	logic                        shutdown_n;

	// Handshake
	assign in_acc   = in_valid && !in_stall;
	assign s1_adv   = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !s1_adv;

	// Gather levels
	assign lv_in[0] = level_0;
	assign lv_in[1] = level_1;
	assign lv_in[2] = level_2;
	assign lv_in[3] = level_3;
	assign lv_in[4] = level_4;
	assign lv_in[5] = level_5;
	assign lv_in[6] = level_6;
	assign lv_in[7] = level_7;

	always_comb begin
		for (int i = 0; i < KEYS; i++) begin
			base_wdata[i*LEVEL_W +: LEVEL_W] = lv_in[i];
		end
	end

	// Baseline memory: calibrate writes the row, every request reads it
	tkns_ram #(
		.WIDTH (tkns_pkg::BASE_W),
		.DEPTH (tkns_pkg::BASE_DEPTH)
	) u_base_ram (
		.clk   (clk),
		.we    (in_acc && (kind == tkns_pkg::KIND_CAL)),
		.waddr (1'b0),
		.wdata (base_wdata),
		.re    (in_acc),
		.raddr (1'b0),
		.rdata (base_rdata)
	);

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_delta_q <= tkns_pkg::SINGLE_DELTA_RST;
			pair_delta_q   <= tkns_pkg::PAIR_DELTA_RST;
			idle_limit_q   <= tkns_pkg::IDLE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tkns_pkg::CFG_SINGLE: single_delta_q <= cfg_data;
				tkns_pkg::CFG_PAIR:   pair_delta_q   <= cfg_data;
				tkns_pkg::CFG_IDLE:   idle_limit_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Baseline row becomes valid with the first calibrate request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_valid_q <= 1'b0;
		end else if (in_acc && (kind == tkns_pkg::KIND_CAL)) begin
			base_valid_q <= 1'b1;
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1   <= kind;
			bvalid_s1 <= base_valid_q;
			for (int i = 0; i < KEYS; i++) begin
				level_s1[i] <= lv_in[i];
			end
		end
	end

	// Compare levels against baselines
	always_comb begin
		logic [LEVEL_W-1:0] base;
		for (int i = 0; i < KEYS; i++) begin
			base = bvalid_s1 ? base_rdata[i*LEVEL_W +: LEVEL_W] : '0;
			above_single[i] = tkns_pkg::rises_over(level_s1[i], base, single_delta_q);
			above_pair[i]   = tkns_pkg::rises_over(level_s1[i], base, pair_delta_q);
		end
	end

	// Build the key mask from single touches and sharp pairs
	always_comb begin
		int a;
		scan_mask = above_single;
		for (int p = 0; p < tkns_pkg::PAIRS; p++) begin
			a = tkns_pkg::PAIR_LO[p];
			if (above_pair[a] && above_pair[a+1]) begin
				scan_mask[a]   = 1'b1;
				scan_mask[a+1] = 1'b1;
			end
		end
	end

	assign hit = tkns_pkg::note_lookup(scan_mask);

	// Player update
	always_comb begin
		ev_n       = tkns_pkg::EV_NONE;
		note_n     = '0;
		period_n   = '0;
		mask_n     = '0;
		held_n     = held_mask_q;
		sounding_n = sounding_q;
		idle_n     = idle_q;
		shutdown_n = shutdown_q;
		if (kind_s1 == tkns_pkg::KIND_SCAN) begin
			mask_n = scan_mask;
			if (scan_mask == '0) begin
				if (sounding_q) begin
					held_n     = '0;
					sounding_n = 1'b0;
					idle_n     = '0;
					ev_n       = tkns_pkg::EV_STOP;
				end
			end else if ((scan_mask != held_mask_q) && hit.hit) begin
				note_n     = hit.idx;
				period_n   = tkns_pkg::note_period(hit.idx);
				sounding_n = 1'b1;
				idle_n     = '0;
				held_n     = scan_mask;
				ev_n       = tkns_pkg::EV_START;
			end
			// Idle counting after the note decision
			if (sounding_n) begin
				idle_n = '0;
			end else begin
				if (idle_n > idle_limit_q) begin
					shutdown_n = 1'b1;
				end
				if (idle_n != {IDLE_W{1'b1}}) begin
					idle_n = idle_n + 1'b1;
				end
			end
		end
	end

	// Commit player state as the request leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_mask_q <= '0;
			sounding_q  <= 1'b0;
			idle_q      <= '0;
			shutdown_q  <= 1'b0;
		end else if (s1_adv) begin
			held_mask_q <= held_n;
			sounding_q  <= sounding_n;
			idle_q      <= idle_n;
			shutdown_q  <= shutdown_n;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			event_q   <= ev_n;
			note_q    <= note_n;
			period_q  <= period_n;
			mask_q    <= mask_n;
			playing_q <= sounding_n;
			power_q   <= shutdown_n;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_res   = event_q;
	assign note_index  = note_q;
	assign note_period = period_q;
	assign key_mask    = mask_q;
	assign playing     = playing_q;
	assign power_off   = power_q;

`ifndef NO_ASSERTIONS
	a_held_when_sounding: assert property (@(posedge clk) disable iff (!arst_n)
		sounding_q |-> (held_mask_q != '0))
		else $error("sounding without a held mask");

	a_clear_when_silent: assert property (@(posedge clk) disable iff (!arst_n)
		!sounding_q |-> (held_mask_q == '0))
		else $error("held mask left over while silent");

	a_idle_zero_sounding: assert property (@(posedge clk) disable iff (!arst_n)
		sounding_q |-> (idle_q == '0))
		else $error("idle counter running while a note sounds");

	a_shutdown_latched: assert property (@(posedge clk) disable iff (!arst_n)
		shutdown_q |=> shutdown_q)
		else $error("power-off flag dropped without reset");

	a_start_plays: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (event_q == tkns_pkg::EV_START)) |-> playing_q)
		else $error("start event reported while not playing");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && out_valid_q && out_stall))
		else $error("input stalled with room in the pipeline");
`endif

endmodule

// ----- rtl/core/tkns_ram.sv -----
// ----------------------------------------------------------------------------
// tkns_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tkns_ram #(
	parameter int WIDTH = tkns_pkg::BASE_W,
	parameter int DEPTH = tkns_pkg::BASE_DEPTH,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
